/* design/rwl_pkg.sv */
// Shared constants, codes, types and ring-pointer helper for the reader-writer lock controller.
// No dependencies; used by every module of the block.
package rwl_pkg;

    localparam int QUEUE_DEPTH       = 16;
    localparam int TASK_ID_BITS      = 8;
    localparam int READER_COUNT_BITS = 9;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 3;

    localparam int IN_W      = TASK_ID_BITS + 1;
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W     = TASK_ID_BITS + STATUS_W;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    localparam logic [OPCODE_W-1:0] OP_WRITE     = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_READ      = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_TRY_WRITE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_TRY_READ  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_UNLOCK    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_GRANTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BUSY    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXCESS  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_GRANT = 1'b1;

    localparam logic [READER_COUNT_BITS-1:0] READER_MAX = {READER_COUNT_BITS{1'b1}};

    typedef logic [TASK_ID_BITS-1:0] task_id_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic grant;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic more;
        logic grant_last;
    } dp_status_t;

    function automatic logic [PTR_W-1:0] ring_add(logic [PTR_W-1:0] p, logic [FILL_W-1:0] n);
        logic [SUM_W-1:0] s;
        s = SUM_W'(p) + SUM_W'(n);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

/* design/rwl_fifo.sv */
// Task-id wait queue: a ring memory with head pointer and fill count, registered read port.
// Depends on rwl_pkg.
module rwl_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rwl_pkg::task_id_t        push_data,
    input  logic                     pop,
    output logic [rwl_pkg::FILL_W-1:0] fill,
    output rwl_pkg::task_id_t        head_data
);

    rwl_pkg::task_id_t              mem [rwl_pkg::QUEUE_DEPTH];
    rwl_pkg::task_id_t              rd_reg;
    logic [rwl_pkg::PTR_W-1:0]      head_reg;
    logic [rwl_pkg::PTR_W-1:0]      head_next;
    logic [rwl_pkg::PTR_W-1:0]      tail;
    logic [rwl_pkg::FILL_W-1:0]     fill_reg;
    logic [rwl_pkg::FILL_W-1:0]     fill_next;

    always_comb
    begin
        head_next = pop ? rwl_pkg::ring_add(head_reg, rwl_pkg::FILL_W'(1)) : head_reg;
        tail      = rwl_pkg::ring_add(head_reg, fill_reg);
        fill_next = fill_reg;
        if (push)
        begin
            fill_next = fill_reg + rwl_pkg::FILL_W'(1);
        end
        else if (pop)
        begin
            fill_next = fill_reg - rwl_pkg::FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // The read address follows the next head so that back-to-back pops see fresh data.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[tail] <= push_data;
        end
        rd_reg <= mem[head_next];
    end

    assign fill      = fill_reg;
    assign head_data = rd_reg;

endmodule

/* design/rwl_datapath.sv */
// Lock state, request decoding, wait queues and the output register of the lock controller.
// Depends on rwl_pkg and rwl_fifo.
module rwl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rwl_pkg::dp_cmd_t              cmd,
    output rwl_pkg::dp_status_t           status,
    input  logic [rwl_pkg::OPCODE_W-1:0]  in_opcode,
    input  rwl_pkg::task_id_t             in_task_id,
    input  logic                          in_is_parallel,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_kind,
    output rwl_pkg::task_id_t             out_task_id,
    output logic [rwl_pkg::STATUS_W-1:0]  out_status,
    output logic                          out_last
);

    logic [rwl_pkg::OPCODE_W-1:0]          op_reg;
    rwl_pkg::task_id_t                     id_reg;
    logic                                  par_reg;

    logic                                  wh_reg;
    logic                                  wh_next;
    logic [rwl_pkg::READER_COUNT_BITS-1:0] cnt_reg;
    logic [rwl_pkg::READER_COUNT_BITS-1:0] cnt_next;

    logic                                  valid_reg;
    logic                                  valid_next;
    logic                                  kind_reg;
    logic                                  kind_next;
    rwl_pkg::task_id_t                     oid_reg;
    rwl_pkg::task_id_t                     oid_next;
    logic [rwl_pkg::STATUS_W-1:0]          st_reg;
    logic [rwl_pkg::STATUS_W-1:0]          st_next;
    logic                                  last_reg;
    logic                                  last_next;

    logic                                  wpush;
    logic                                  rpush;
    logic                                  wpop;
    logic                                  rpop;
    logic [rwl_pkg::FILL_W-1:0]            wfill;
    logic [rwl_pkg::FILL_W-1:0]            rfill;
    rwl_pkg::task_id_t                     wdata;
    rwl_pkg::task_id_t                     rdata;

    logic                                  wfull;
    logic                                  rfull;
    logic                                  readers_blocked;
    logic                                  released;
    logic [rwl_pkg::STATUS_W-1:0]          exec_st;
    logic                                  more;
    logic                                  grant_last;

    rwl_fifo u_wq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (wpush),
        .push_data (id_reg),
        .pop       (wpop),
        .fill      (wfill),
        .head_data (wdata)
    );

    rwl_fifo u_rq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rpush),
        .push_data (id_reg),
        .pop       (rpop),
        .fill      (rfill),
        .head_data (rdata)
    );

    always_comb
    begin
        wfull           = (wfill == rwl_pkg::FILL_W'(rwl_pkg::QUEUE_DEPTH));
        rfull           = (rfill == rwl_pkg::FILL_W'(rwl_pkg::QUEUE_DEPTH));
        readers_blocked = wh_reg || ((cnt_reg != '0) && (wfill != '0));

        wh_next    = wh_reg;
        cnt_next   = cnt_reg;
        wpush      = 1'b0;
        rpush      = 1'b0;
        wpop       = 1'b0;
        rpop       = 1'b0;
        released   = 1'b0;
        exec_st    = rwl_pkg::ST_INVALID;
        grant_last = 1'b1;

        unique case (op_reg) inside
            rwl_pkg::OP_WRITE, rwl_pkg::OP_TRY_WRITE:
            begin
                if ((op_reg == rwl_pkg::OP_WRITE) && par_reg)
                begin
                    exec_st = rwl_pkg::ST_INVALID;
                end
                else if (wh_reg || (cnt_reg != '0))
                begin
                    if (op_reg == rwl_pkg::OP_TRY_WRITE)
                    begin
                        exec_st = rwl_pkg::ST_BUSY;
                    end
                    else if (wfull)
                    begin
                        exec_st = rwl_pkg::ST_FULL;
                    end
                    else
                    begin
                        exec_st = rwl_pkg::ST_QUEUED;
                        wpush   = cmd.exec;
                    end
                end
                else
                begin
                    exec_st = rwl_pkg::ST_GRANTED;
                    wh_next = 1'b1;
                end
            end
            rwl_pkg::OP_READ, rwl_pkg::OP_TRY_READ:
            begin
                if ((op_reg == rwl_pkg::OP_READ) && par_reg)
                begin
                    exec_st = rwl_pkg::ST_INVALID;
                end
                else if (readers_blocked)
                begin
                    if (op_reg == rwl_pkg::OP_TRY_READ)
                    begin
                        exec_st = rwl_pkg::ST_BUSY;
                    end
                    else if (rfull)
                    begin
                        exec_st = rwl_pkg::ST_FULL;
                    end
                    else
                    begin
                        exec_st = rwl_pkg::ST_QUEUED;
                        rpush   = cmd.exec;
                    end
                end
                else if (cnt_reg == rwl_pkg::READER_MAX)
                begin
                    exec_st = rwl_pkg::ST_BUSY;
                end
                else
                begin
                    exec_st  = rwl_pkg::ST_GRANTED;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rwl_pkg::OP_UNLOCK:
            begin
                if (wh_reg)
                begin
                    wh_next  = 1'b0;
                    released = 1'b1;
                    exec_st  = rwl_pkg::ST_GRANTED;
                end
                else if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                    released = 1'b1;
                    exec_st  = rwl_pkg::ST_GRANTED;
                end
                else
                begin
                    exec_st = rwl_pkg::ST_EXCESS;
                end
            end
            default:
            begin
                exec_st = rwl_pkg::ST_INVALID;
            end
        endcase

        more = released && (cnt_next == '0) && ((wfill != '0) || (rfill != '0));

        if (cmd.grant)
        begin
            if (wfill != '0)
            begin
                wpop       = 1'b1;
                wh_next    = 1'b1;
                grant_last = 1'b1;
            end
            else
            begin
                rpop       = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                grant_last = (rfill == rwl_pkg::FILL_W'(1))
                    || (cnt_next == rwl_pkg::READER_MAX);
            end
        end

        valid_next = out_ready ? 1'b0 : valid_reg;
        kind_next  = kind_reg;
        oid_next   = oid_reg;
        st_next    = st_reg;
        last_next  = last_reg;
        if (cmd.exec)
        begin
            valid_next = 1'b1;
            kind_next  = rwl_pkg::KIND_REPLY;
            oid_next   = id_reg;
            st_next    = exec_st;
            last_next  = !more;
        end
        else if (cmd.grant)
        begin
            valid_next = 1'b1;
            kind_next  = rwl_pkg::KIND_GRANT;
            oid_next   = (wfill != '0) ? wdata : rdata;
            st_next    = rwl_pkg::ST_GRANTED;
            last_next  = grant_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wh_reg    <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.exec || cmd.grant)
            begin
                wh_reg  <= wh_next;
                cnt_reg <= cnt_next;
            end
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_opcode;
            id_reg  <= in_task_id;
            par_reg <= in_is_parallel;
        end
        kind_reg <= kind_next;
        oid_reg  <= oid_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

    assign status.out_free   = !valid_reg || out_ready;
    assign status.more       = more;
    assign status.grant_last = grant_last;

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_task_id = oid_reg;
    assign out_status  = st_reg;
    assign out_last    = last_reg;

endmodule

/* design/rwl_ctrl.sv */
// Sequencer of the lock controller: takes a request, resolves it, then hands out queued grants.
// Depends on rwl_pkg.
module rwl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output rwl_pkg::dp_cmd_t    cmd,
    input  rwl_pkg::dp_status_t status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DRAIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = status.more ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (status.out_free)
                begin
                    cmd.grant  = 1'b1;
                    state_next = status.grant_last ? S_IDLE : S_DRAIN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

/* design/rw_lock_grant_controller.sv */
// Top level of the reader-writer lock controller: stream ports, sequencer and datapath.
// Depends on rwl_pkg, rwl_ctrl and rwl_datapath.
//
// Each request beat produces one reply beat, and an unlock that frees the lock is followed
// by grant beats for waiting tasks; m_tlast marks the final beat of a request. A request is
// first accepted and then resolved against the lock state. An unlock that releases the lock
// then hands out its grants, a single writer or up to the queue depth of readers, from the
// wait queue one read per cycle while the output register is free. The result
// register lets a new request be accepted while a result waits, and a stalled master side holds
// the sequencer in place.
module rw_lock_grant_controller (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // task_id, is_parallel, zero padding
    input  logic [rwl_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [rwl_pkg::OPCODE_W-1:0]    s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // task_id_out, status, zero padding
    output logic [rwl_pkg::M_TDATA_W-1:0]   m_tdata,
    // kind
    output logic                            m_tuser,
    output logic                            m_tlast
);

    rwl_pkg::dp_cmd_t             cmd;
    rwl_pkg::dp_status_t          status;
    rwl_pkg::task_id_t            out_task_id;
    logic [rwl_pkg::STATUS_W-1:0] out_status;

    rwl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rwl_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_opcode      (s_tuser),
        .in_task_id     (s_tdata[rwl_pkg::TASK_ID_BITS-1:0]),
        .in_is_parallel (s_tdata[rwl_pkg::TASK_ID_BITS]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_kind       (m_tuser),
        .out_task_id    (out_task_id),
        .out_status     (out_status),
        .out_last       (m_tlast)
    );

    assign m_tdata = rwl_pkg::M_TDATA_W'({out_status, out_task_id});

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for rw_lock_grant_controller: directed rows, a queue-full and hand-off
// sequence, then mode-driven random requests under random stalls on both sides.
// Depends on rwl_pkg and the rw_lock_grant_controller RTL.
module tb_top;

    import rwl_pkg::*;

    localparam int CLK_PERIOD = 20;

    localparam logic [OPCODE_W-1:0] OP_UNDEF_LO  = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_MID = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_UNDEF_HI  = 3'd7;

    typedef struct packed {
        logic                kind;
        task_id_t            id;
        logic [STATUS_W-1:0] status;
        logic                last;
    } beat_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        task_id_t            id;
        logic                par;
        logic                has_exp;
        logic [STATUS_W-1:0] exp_st;
    } stim_row_t;

    localparam int N_ROWS = 21;

    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{OP_UNLOCK,    8'h00, 1'b0, 1'b1, ST_EXCESS},
        '{OP_UNDEF_LO,  8'hFF, 1'b0, 1'b1, ST_INVALID},
        '{OP_UNDEF_MID, 8'h5A, 1'b0, 1'b1, ST_INVALID},
        '{OP_UNDEF_HI,  8'hA5, 1'b1, 1'b1, ST_INVALID},
        '{OP_WRITE,     8'h80, 1'b1, 1'b1, ST_INVALID},
        '{OP_READ,      8'h7F, 1'b1, 1'b1, ST_INVALID},
        '{OP_TRY_READ,  8'h01, 1'b1, 1'b1, ST_GRANTED},
        '{OP_TRY_WRITE, 8'h02, 1'b0, 1'b1, ST_BUSY},
        '{OP_WRITE,     8'hFF, 1'b0, 1'b0, ST_GRANTED},
        '{OP_READ,      8'h00, 1'b0, 1'b0, ST_GRANTED},
        '{OP_TRY_READ,  8'h55, 1'b0, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'h01, 1'b0, 1'b0, ST_GRANTED},
        '{OP_READ,      8'hAA, 1'b0, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'hFF, 1'b1, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'h00, 1'b0, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'hAA, 1'b0, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'h33, 1'b0, 1'b1, ST_EXCESS},
        '{OP_TRY_WRITE, 8'h7F, 1'b1, 1'b1, ST_GRANTED},
        '{OP_WRITE,     8'h3C, 1'b0, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'h7F, 1'b0, 1'b0, ST_GRANTED},
        '{OP_UNLOCK,    8'h3C, 1'b0, 1'b0, ST_GRANTED}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [OPCODE_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;

    logic                          wr_held;
    logic [READER_COUNT_BITS-1:0]  rdr_cnt;
    task_id_t                      wr_wait [$];
    task_id_t                      rd_wait [$];
    beat_t                         pending_beats [$];

    int err_count  = 0;
    int burst_left = 0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_hold    = 0;

    rw_lock_grant_controller u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Resolves one accepted request against the lock state and queues the beats it causes.
    task automatic resolve_request(input logic [OPCODE_W-1:0] op, input task_id_t id,
                                   input logic par, input logic has_exp,
                                   input logic [STATUS_W-1:0] exp_st);
        beat_t               outs [$];
        logic [STATUS_W-1:0] st;
        logic                blocked;
        st = ST_INVALID;
        case (op)
            OP_WRITE, OP_TRY_WRITE:
            begin
                if (op == OP_WRITE && par)
                    st = ST_INVALID;
                else if (wr_held || rdr_cnt != '0)
                begin
                    if (op == OP_TRY_WRITE)
                        st = ST_BUSY;
                    else if (wr_wait.size() < QUEUE_DEPTH)
                    begin
                        wr_wait.push_back(id);
                        st = ST_QUEUED;
                    end
                    else
                        st = ST_FULL;
                end
                else
                begin
                    wr_held = 1'b1;
                    st = ST_GRANTED;
                end
                outs.push_back('{KIND_REPLY, id, st, 1'b0});
            end
            OP_READ, OP_TRY_READ:
            begin
                blocked = wr_held || (rdr_cnt != '0 && wr_wait.size() != 0);
                if (op == OP_READ && par)
                    st = ST_INVALID;
                else if (blocked)
                begin
                    if (op == OP_TRY_READ)
                        st = ST_BUSY;
                    else if (rd_wait.size() < QUEUE_DEPTH)
                    begin
                        rd_wait.push_back(id);
                        st = ST_QUEUED;
                    end
                    else
                        st = ST_FULL;
                end
                else if (rdr_cnt == READER_MAX)
                    st = ST_BUSY;
                else
                begin
                    rdr_cnt = rdr_cnt + 1'b1;
                    st = ST_GRANTED;
                end
                outs.push_back('{KIND_REPLY, id, st, 1'b0});
            end
            OP_UNLOCK:
            begin
                if (!wr_held && rdr_cnt == '0)
                    outs.push_back('{KIND_REPLY, id, ST_EXCESS, 1'b0});
                else
                begin
                    if (wr_held)
                        wr_held = 1'b0;
                    else
                        rdr_cnt = rdr_cnt - 1'b1;
                    outs.push_back('{KIND_REPLY, id, ST_GRANTED, 1'b0});
                    if (rdr_cnt == '0)
                    begin
                        if (wr_wait.size() != 0)
                        begin
                            wr_held = 1'b1;
                            outs.push_back('{KIND_GRANT, wr_wait.pop_front(), ST_GRANTED, 1'b0});
                        end
                        else
                        begin
                            while (rd_wait.size() != 0 && rdr_cnt != READER_MAX)
                            begin
                                rdr_cnt = rdr_cnt + 1'b1;
                                outs.push_back('{KIND_GRANT, rd_wait.pop_front(), ST_GRANTED,
                                                 1'b0});
                            end
                        end
                    end
                end
            end
            default:
                outs.push_back('{KIND_REPLY, id, ST_INVALID, 1'b0});
        endcase
        outs[outs.size() - 1].last = 1'b1;
        if (has_exp)
        begin
            outs.delete();
            outs.push_back('{KIND_REPLY, id, exp_st, 1'b1});
        end
        foreach (outs[i])
            pending_beats.push_back(outs[i]);
    endtask

    task automatic issue_request(input logic [OPCODE_W-1:0] op, input task_id_t id,
                                 input logic par, input logic has_exp,
                                 input logic [STATUS_W-1:0] exp_st);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({par, id});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        resolve_request(op, id, par, has_exp, exp_st);
        burst_left--;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_beats.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    function automatic logic [OPCODE_W-1:0] pick_op(input int mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            0:       return (r < 40) ? OP_READ : (r < 60) ? OP_TRY_READ :
                            (r < 88) ? OP_UNLOCK : (r < 96) ? OP_WRITE : OP_TRY_WRITE;
            1:       return (r < 40) ? OP_WRITE : (r < 60) ? OP_TRY_WRITE :
                            (r < 88) ? OP_UNLOCK : (r < 96) ? OP_READ : OP_TRY_READ;
            2:       return (r < 70) ? OP_UNLOCK : (r < 80) ? OP_READ :
                            (r < 90) ? OP_WRITE : OP_TRY_READ;
            default: return OPCODE_W'($urandom_range(0, 7));
        endcase
    endfunction

    // The receiver stalls on its own schedule: always ready, coin flips, or long holds.
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default:
            begin
                if (rx_hold != 0)
                begin
                    rx_hold--;
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                    rx_hold = $urandom_range(0, 7);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tuser, m_tdata[TASK_ID_BITS-1:0], m_tdata[TASK_ID_BITS +: STATUS_W],
                    m_tlast};
            if (pending_beats.size() == 0)
            begin
                if (err_count < 10)
                    $display("unexpected beat: kind=%0d id=%02h status=%0d last=%0d",
                             got.kind, got.id, got.status, got.last);
                err_count++;
            end
            else
            begin
                want = pending_beats.pop_front();
                if (got != want)
                begin
                    if (err_count < 10)
                        $display({"mismatch: expected kind=%0d id=%02h status=%0d last=%0d,",
                                  " got kind=%0d id=%02h status=%0d last=%0d"},
                                 want.kind, want.id, want.status, want.last,
                                 got.kind, got.id, got.status, got.last);
                    err_count++;
                end
            end
        end
    end

    initial
    begin
        #(CLK_PERIOD * 1500000);
        $display("FAIL rw_lock_grant_controller");
        $finish;
    end

    initial
    begin
        int mode;
        int mode_left;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_WRITE;
        wr_held  = 1'b0;
        rdr_cnt  = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            issue_request(DIR_ROWS[i].op, DIR_ROWS[i].id, DIR_ROWS[i].par,
                          DIR_ROWS[i].has_exp, DIR_ROWS[i].exp_st);
        wait_drained();

        // Both wait queues overflow, then a chain of writer hand-offs ends in a full reader drain.
        issue_request(OP_WRITE, task_id_t'($urandom), 1'b0, 1'b0, ST_GRANTED);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            issue_request(OP_READ, task_id_t'($urandom), 1'b0, 1'b0, ST_GRANTED);
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            issue_request(OP_WRITE, task_id_t'($urandom), 1'b0, 1'b0, ST_GRANTED);
        while (wr_held || rdr_cnt != '0)
            issue_request(OP_UNLOCK, task_id_t'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                          ST_GRANTED);
        wait_drained();

        mode = 0;
        mode_left = 0;
        for (int i = 0; i < 370; i++)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 4);
                mode_left = $urandom_range(8, 30);
            end
            mode_left--;
            issue_request(pick_op(mode), task_id_t'($urandom),
                          (mode == 4) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0),
                          1'b0, ST_GRANTED);
            if (i == 185)
                wait_drained();
        end
        wait_drained();
        repeat (40) @(posedge clk);

        if (err_count == 0 && pending_beats.size() == 0)
            $display("PASS rw_lock_grant_controller");
        else
            $display("FAIL rw_lock_grant_controller");
        $finish;
    end

endmodule

/* filelist.f */
design/rwl_pkg.sv
design/rwl_fifo.sv
design/rwl_datapath.sv
design/rwl_ctrl.sv
design/rw_lock_grant_controller.sv
verif/tb_top.sv
